[rtl/redundant_state_mismatch_monitor_core_defines.svh]
// assertion macros for the mismatch monitor
`ifndef REDUNDANT_STATE_MISMATCH_MONITOR_CORE_DEFINES_SVH
`define REDUNDANT_STATE_MISMATCH_MONITOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RSMM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rsmm assertion failed");

// next-cycle implication
`define RSMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rsmm assertion failed");

`else

`define RSMM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RSMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/rsmm_pkg.sv]
`default_nettype none

package rsmm_pkg;

	localparam int NumCh   = 5;
	localparam int AgeW    = 16;
	localparam int PosW    = 24;
	localparam int PairW   = 2 * PosW;
	localparam int SqW     = 2 * PosW;
	localparam int SumW    = SqW + 1;
	localparam int LimW    = 16;
	localparam int LimSqW  = 2 * LimW;
	localparam int CodeW   = 8;
	localparam int DigestW = 64;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 16;

	localparam logic [AgeW-1:0]  TimeoutReset = AgeW'(10);
	localparam logic [LimW-1:0]  DistReset    = LimW'(100);
	localparam logic [CodeW-1:0] NormalReset  = CodeW'(1);
	localparam logic [CodeW-1:0] NoBehReset   = CodeW'(1);

	localparam int ChPos    = 0;
	localparam int ChMode   = 1;
	localparam int ChLoc    = 2;
	localparam int ChRtStat = 3;
	localparam int ChRoute  = 4;

	typedef enum logic [3:0] {
		CMD_FAULT      = 4'd0,
		CMD_MAIN_POS   = 4'd1,
		CMD_SUB_POS    = 4'd2,
		CMD_MAIN_MODE  = 4'd3,
		CMD_SUB_MODE   = 4'd4,
		CMD_MAIN_LOC   = 4'd5,
		CMD_SUB_LOC    = 4'd6,
		CMD_MAIN_RTST  = 4'd7,
		CMD_SUB_RTST   = 4'd8,
		CMD_MAIN_ROUTE = 4'd9,
		CMD_SUB_ROUTE  = 4'd10,
		CMD_TICK       = 4'd11
	} cmd_t;

	typedef enum logic [1:0] {
		LVL_OK    = 2'd0,
		LVL_WARN  = 2'd1,
		LVL_ERROR = 2'd2
	} level_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_DIST    = 2'd1,
		CFG_NORMAL  = 2'd2,
		CFG_NO_BEH  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]          command;
		logic signed [23:0]  pos_x;
		logic signed [23:0]  pos_y;
		logic [CodeW-1:0]    state_code;
		logic [CodeW-1:0]    behavior_code;
		logic                control_enabled;
		logic [DigestW-1:0]  route_digest;
	} item_t;

	typedef struct packed {
		level_t level;
		logic   position_timed_out;
		logic   mode_timed_out;
		logic   localization_timed_out;
		logic   route_status_timed_out;
		logic   route_timed_out;
	} result_t;

	// tick snapshot carried down the distance pipeline
	typedef struct packed {
		logic                tick;
		logic                auton;
		logic                pos_both;
		logic [NumCh-2:0]    other_eq;
	} snap_t;

endpackage

`default_nettype wire

[rtl/rsmm_update.sv]
`default_nettype none

module rsmm_update
	import rsmm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              item_valid,
	input  wire item_t             item,
	input  wire logic [CodeW-1:0]  normal_code,
	input  wire logic [CodeW-1:0]  no_beh_code,
	output logic [PairW-1:0]       main_pos,
	output logic [PairW-1:0]       sub_pos,
	output snap_t                  snap
);

	logic                 valid_s1;
	item_t                item_s1;
	cmd_t                 cmd;
	logic                 upd;
	logic                 auton_q;
	logic [NumCh-1:0]     main_rcv_q;
	logic [NumCh-1:0]     sub_rcv_q;
	logic [NumCh-1:0]     both;
	logic [PairW-1:0]     main_pos_q;
	logic [PairW-1:0]     sub_pos_q;
	logic [CodeW:0]       main_mode_q;
	logic [CodeW:0]       sub_mode_q;
	logic [CodeW-1:0]     main_loc_q;
	logic [CodeW-1:0]     sub_loc_q;
	logic [CodeW-1:0]     main_rtst_q;
	logic [CodeW-1:0]     sub_rtst_q;
	logic [DigestW-1:0]   main_hash_q;
	logic [DigestW-1:0]   sub_hash_q;

	assign cmd  = cmd_t'(item_s1.command);
	assign upd  = valid_s1 && advance;
	assign both = main_rcv_q & sub_rcv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auton_q    <= 1'b1;
			main_rcv_q <= '0;
			sub_rcv_q  <= '0;
		end else if (upd) begin
			unique case (cmd)
				CMD_FAULT: begin
					auton_q <= (item_s1.state_code == normal_code) &&
						(item_s1.behavior_code == no_beh_code);
				end
				CMD_MAIN_POS:   main_rcv_q[ChPos]    <= 1'b1;
				CMD_SUB_POS:    sub_rcv_q[ChPos]     <= 1'b1;
				CMD_MAIN_MODE:  main_rcv_q[ChMode]   <= 1'b1;
				CMD_SUB_MODE:   sub_rcv_q[ChMode]    <= 1'b1;
				CMD_MAIN_LOC:   main_rcv_q[ChLoc]    <= 1'b1;
				CMD_SUB_LOC:    sub_rcv_q[ChLoc]     <= 1'b1;
				CMD_MAIN_RTST:  main_rcv_q[ChRtStat] <= 1'b1;
				CMD_SUB_RTST:   sub_rcv_q[ChRtStat]  <= 1'b1;
				CMD_MAIN_ROUTE: main_rcv_q[ChRoute]  <= 1'b1;
				CMD_SUB_ROUTE:  sub_rcv_q[ChRoute]   <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			unique case (cmd)
				CMD_MAIN_POS:   main_pos_q  <= {item_s1.pos_y, item_s1.pos_x};
				CMD_SUB_POS:    sub_pos_q   <= {item_s1.pos_y, item_s1.pos_x};
				CMD_MAIN_MODE:  main_mode_q <= {item_s1.control_enabled, item_s1.state_code};
				CMD_SUB_MODE:   sub_mode_q  <= {item_s1.control_enabled, item_s1.state_code};
				CMD_MAIN_LOC:   main_loc_q  <= item_s1.state_code;
				CMD_SUB_LOC:    sub_loc_q   <= item_s1.state_code;
				CMD_MAIN_RTST:  main_rtst_q <= item_s1.state_code;
				CMD_SUB_RTST:   sub_rtst_q  <= item_s1.state_code;
				CMD_MAIN_ROUTE: main_hash_q <= item_s1.route_digest;
				CMD_SUB_ROUTE:  sub_hash_q  <= item_s1.route_digest;
				default: begin
				end
			endcase
		end
	end

	// channel compare as seen by a tick in this stage
	always_comb begin
		snap.tick     = valid_s1 && (cmd == CMD_TICK);
		snap.auton    = auton_q;
		snap.pos_both = both[ChPos];
		snap.other_eq[ChMode-1]   = !both[ChMode]   || (main_mode_q == sub_mode_q);
		snap.other_eq[ChLoc-1]    = !both[ChLoc]    || (main_loc_q == sub_loc_q);
		snap.other_eq[ChRtStat-1] = !both[ChRtStat] || (main_rtst_q == sub_rtst_q);
		snap.other_eq[ChRoute-1]  = !both[ChRoute]  || (main_hash_q == sub_hash_q);
	end

	assign main_pos = main_pos_q;
	assign sub_pos  = sub_pos_q;

endmodule

`default_nettype wire

[rtl/rsmm_pos_cmp.sv]
`default_nettype none

module rsmm_pos_cmp
	import rsmm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [PairW-1:0]  main_pos,
	input  wire logic [PairW-1:0]  sub_pos,
	input  wire logic [LimW-1:0]   dist_limit,
	input  wire snap_t             snap_in,
	output snap_t                  snap_s4,
	output logic                   pos_eq_s4
);

	logic signed [PosW:0]  dx_d;
	logic signed [PosW:0]  dy_d;
	logic [PosW-1:0]       dx_abs;
	logic [PosW-1:0]       dy_abs;
	logic [PosW-1:0]       dx_s2;
	logic [PosW-1:0]       dy_s2;
	logic [SqW-1:0]        dx2_s3;
	logic [SqW-1:0]        dy2_s3;
	logic [LimSqW-1:0]     lim_sq_s3;
	logic [SumW-1:0]       dist_sq;
	snap_t                 snap_s2;
	snap_t                 snap_s3;

	always_comb begin
		dx_d = $signed({main_pos[PosW-1], main_pos[PosW-1:0]}) -
			$signed({sub_pos[PosW-1], sub_pos[PosW-1:0]});
		dy_d = $signed({main_pos[PairW-1], main_pos[PairW-1:PosW]}) -
			$signed({sub_pos[PairW-1], sub_pos[PairW-1:PosW]});
		dx_abs = dx_d[PosW] ? PosW'(-dx_d) : dx_d[PosW-1:0];
		dy_abs = dy_d[PosW] ? PosW'(-dy_d) : dy_d[PosW-1:0];
	end

	assign dist_sq = {1'b0, dx2_s3} + {1'b0, dy2_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_s2 <= '0;
			snap_s3 <= '0;
			snap_s4 <= '0;
		end else if (advance) begin
			snap_s2 <= snap_in;
			snap_s3 <= snap_s2;
			snap_s4 <= snap_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s2     <= dx_abs;
			dy_s2     <= dy_abs;
			dx2_s3    <= SqW'(dx_s2) * SqW'(dx_s2);
			dy2_s3    <= SqW'(dy_s2) * SqW'(dy_s2);
			lim_sq_s3 <= LimSqW'(dist_limit) * LimSqW'(dist_limit);
			pos_eq_s4 <= dist_sq <= SumW'(lim_sq_s3);
		end
	end

endmodule

`default_nettype wire

[rtl/rsmm_age.sv]
`default_nettype none

`include "redundant_state_mismatch_monitor_core_defines.svh"

module rsmm_age
	import rsmm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire snap_t            snap_s4,
	input  wire logic             pos_eq_s4,
	input  wire logic [AgeW-1:0]  timeout,
	input  wire logic             result_stall,
	output logic                  advance,
	output logic                  result_valid,
	output result_t               result
);

	localparam logic [AgeW-1:0] AgeTop = {AgeW{1'b1}};

	logic [AgeW-1:0]   age_q [NumCh];
	logic [AgeW-1:0]   age_inc [NumCh];
	logic [AgeW-1:0]   age_d [NumCh];
	logic [NumCh-1:0]  eq;
	logic [NumCh-1:0]  timed;
	logic              res_new;
	logic              result_valid_q;
	result_t           result_q;
	result_t           result_d;

	assign advance = !(result_valid_q && result_stall);
	assign res_new = snap_s4.tick && snap_s4.auton;
	assign eq      = {snap_s4.other_eq, !snap_s4.pos_both || pos_eq_s4};

	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			age_inc[ch] = (age_q[ch] == AgeTop) ? age_q[ch] : age_q[ch] + 1'b1;
			age_d[ch]   = (snap_s4.auton && eq[ch]) ? '0 : age_inc[ch];
			timed[ch]   = snap_s4.auton && !eq[ch] && (age_inc[ch] > timeout);
		end
	end

	always_comb begin
		result_d.position_timed_out     = timed[ChPos];
		result_d.mode_timed_out         = timed[ChMode];
		result_d.localization_timed_out = timed[ChLoc];
		result_d.route_status_timed_out = timed[ChRtStat];
		result_d.route_timed_out        = timed[ChRoute];
		priority if (|timed[NumCh-1:ChMode]) begin
			result_d.level = LVL_ERROR;
		end else if (timed[ChPos]) begin
			result_d.level = LVL_WARN;
		end else begin
			result_d.level = LVL_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < NumCh; ch++) begin
				age_q[ch] <= '0;
			end
		end else if (advance && snap_s4.tick) begin
			for (int ch = 0; ch < NumCh; ch++) begin
				age_q[ch] <= age_d[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= res_new;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_new) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RSMM_ASSERT_NEXT(a_no_stray_word, clk, arst_n, advance && !res_new, !result_valid_q)
	`RSMM_ASSERT_IMP(a_warn_pos_only, clk, arst_n, result_valid_q && result_q.level == LVL_WARN, result_q.position_timed_out && !result_q.mode_timed_out && !result_q.localization_timed_out && !result_q.route_status_timed_out && !result_q.route_timed_out)
	`RSMM_ASSERT_NEXT(a_held_tick_ages, clk, arst_n, advance && snap_s4.tick && !snap_s4.auton, age_q[ChPos] != '0 && age_q[ChRoute] != '0)

endmodule

`default_nettype wire

[rtl/redundant_state_mismatch_monitor_core.sv]
`default_nettype none

// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   item (item_t)
// result    out        result_valid / result_stall  result (result_t)
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// one word accepted per cycle while item_stall is low; a tick word accepted while autonomous
// raises result_valid after s1, the distance pipeline (s2 to s4) and the result register, no iteration
// reset clears ages, received flags and control; autonomous comes up set, no clearing pass
// a held result with result_stall high freezes the whole pipeline and raises item_stall

module redundant_state_mismatch_monitor_core
	import rsmm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire item_t               item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output result_t                  result,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgW-1:0]     cfg_data
);

	logic [AgeW-1:0]   timeout_q;
	logic [LimW-1:0]   dist_q;
	logic [CodeW-1:0]  normal_q;
	logic [CodeW-1:0]  no_beh_q;
	logic              advance;
	logic [PairW-1:0]  main_pos;
	logic [PairW-1:0]  sub_pos;
	snap_t             snap_s1;
	snap_t             snap_s4;
	logic              pos_eq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			dist_q    <= DistReset;
			normal_q  <= NormalReset;
			no_beh_q  <= NoBehReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT: timeout_q <= AgeW'(cfg_data);
				CFG_DIST:    dist_q    <= LimW'(cfg_data);
				CFG_NORMAL:  normal_q  <= cfg_data[CodeW-1:0];
				CFG_NO_BEH:  no_beh_q  <= cfg_data[CodeW-1:0];
			endcase
		end
	end

	assign item_stall = !advance;

	rsmm_update u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item_valid  (item_valid),
		.item        (item),
		.normal_code (normal_q),
		.no_beh_code (no_beh_q),
		.main_pos    (main_pos),
		.sub_pos     (sub_pos),
		.snap        (snap_s1)
	);

	rsmm_pos_cmp u_pos_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.main_pos   (main_pos),
		.sub_pos    (sub_pos),
		.dist_limit (dist_q),
		.snap_in    (snap_s1),
		.snap_s4    (snap_s4),
		.pos_eq_s4  (pos_eq_s4)
	);

	rsmm_age u_age (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s4      (snap_s4),
		.pos_eq_s4    (pos_eq_s4),
		.timeout      (timeout_q),
		.result_stall (result_stall),
		.advance      (advance),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
